// ----- hdl/pfd_pkg.sv -----
package pfd_pkg;

	localparam int GRID_SIDE   = 5;
	localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
	localparam int NUM_LETTERS = 26;
	localparam int LW          = 5;   // letter and cell code width
	localparam int RW          = 3;   // row and column width

	localparam logic [LW-1:0] LETTER_I = 5'd8;
	localparam logic [LW-1:0] LETTER_J = 5'd9;
	localparam logic [LW-1:0] LETTER_Z = 5'd25;
	localparam logic [LW-1:0] LAST_CELL = LW'(GRID_CELLS - 1);

	// command codes
	localparam logic [1:0] CMD_KEY     = 2'd0;
	localparam logic [1:0] CMD_FINISH  = 2'd1;
	localparam logic [1:0] CMD_DECRYPT = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_READY = 2'd1;
	localparam logic [1:0] STAT_REPEAT    = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEY,
		ST_FILL,
		ST_CA,
		ST_CB,
		ST_KA,
		ST_KB,
		ST_PB,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic          we;
		logic [LW-1:0] waddr;
		logic [LW-1:0] wdata;
		logic [LW-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [LW-1:0] plain_a;
		logic [LW-1:0] plain_b;
		logic [1:0]    status;
	} result_t;

	// row of a cell index 0..24: idx*13 >> 6 equals idx / 5 over that range
	function automatic logic [RW-1:0] cell_row(input logic [LW-1:0] idx);
		logic [9:0] p;
		p = 10'(idx) * 10'd13;
		return p[8:6];
	endfunction

	function automatic logic [RW-1:0] cell_col(input logic [LW-1:0] idx);
		logic [LW-1:0] base;
		base = 5'({2'b00, cell_row(idx)} * 5'(GRID_SIDE));
		return RW'(idx - base);
	endfunction

	function automatic logic [LW-1:0] cell_of(input logic [RW-1:0] r, input logic [RW-1:0] c);
		return 5'({2'b00, r} * 5'(GRID_SIDE)) + 5'({2'b00, c});
	endfunction

	// one cell back with wrap
	function automatic logic [RW-1:0] step_back(input logic [RW-1:0] x);
		return (x == '0) ? RW'(GRID_SIDE - 1) : x - 3'd1;
	endfunction

	// alphabet without J
	function automatic logic [LW-1:0] fill_letter(input logic [LW-1:0] i);
		return (i <= LETTER_I) ? i : i + 5'd1;
	endfunction

	function automatic logic [LW-1:0] fold_j(input logic [LW-1:0] l);
		return (l == LETTER_J) ? LETTER_I : l;
	endfunction

	function automatic logic [LW-1:0] norm_cipher(input logic [LW-1:0] l);
		return (l > LETTER_Z) ? LETTER_Z : fold_j(l);
	endfunction

endpackage

// ----- hdl/pfd_ram.sv -----
module pfd_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 25
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write one entry, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- hdl/pfd_seq.sv -----
module pfd_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_cmd,
	input  logic [4:0]         in_a,
	input  logic [4:0]         in_b,
	output pfd_pkg::ram_req_t  key_req,
	input  logic [4:0]         key_rdata,
	output pfd_pkg::ram_req_t  cell_req,
	input  logic [4:0]         cell_rdata,
	output logic               res_valid,
	input  logic               res_ready,
	output pfd_pkg::result_t   res
);
	import pfd_pkg::*;

	state_t                 state_q, state_d;
	logic [1:0]             cmd_q;
	logic [LW-1:0]          a_q, b_q;
	logic [LW-1:0]          ca_q, cb_q;
	logic [LW-1:0]          idx_q;
	logic [LW-1:0]          fill_q;
	logic [NUM_LETTERS-1:0] seen_q;
	logic                   ready_q;
	result_t                res_q;

	logic                   accept;
	logic [LW-1:0]          put_letter;
	logic                   put_seen;
	logic                   do_place;
	logic [LW-1:0]          cb_cur;
	logic [RW-1:0]          ra, ka, rb, kb;
	logic [LW-1:0]          ta, tb;

	assign accept = in_valid && in_ready;

	// letter to place: keyword letter or next fill letter
	always_comb begin
		put_letter = (state_q == ST_KEY) ? a_q : fill_letter(idx_q);
		put_seen   = (put_letter <= LETTER_Z) ? seen_q[put_letter] : 1'b1;
		do_place   = ((state_q == ST_KEY) || (state_q == ST_FILL)) && !put_seen;
	end

	// shared position decode and decrypt rule
	always_comb begin
		cb_cur = (state_q == ST_KA) ? cell_rdata : cb_q;
		ra = cell_row(ca_q);
		ka = cell_col(ca_q);
		rb = cell_row(cb_cur);
		kb = cell_col(cb_cur);
		if (ra == rb) begin
			ta = cell_of(ra, step_back(ka));
			tb = cell_of(rb, step_back(kb));
		end else if (ka == kb) begin
			ta = cell_of(step_back(ra), ka);
			tb = cell_of(step_back(rb), kb);
		end else begin
			ta = cell_of(ra, kb);
			tb = cell_of(rb, ka);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (in_cmd == CMD_KEY) begin
						state_d = ST_KEY;
					end else if (in_cmd == CMD_FINISH && !ready_q) begin
						state_d = ST_FILL;
					end else if (in_cmd == CMD_DECRYPT && ready_q) begin
						state_d = ST_CA;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_KEY:  state_d = ST_EMIT;
			ST_FILL: state_d = (idx_q == LAST_CELL) ? ST_EMIT : ST_FILL;
			ST_CA:   state_d = ST_CB;
			ST_CB:   state_d = ST_KA;
			ST_KA:   state_d = ST_KB;
			ST_KB:   state_d = ST_PB;
			ST_PB:   state_d = ST_EMIT;
			ST_EMIT: state_d = res_ready ? ST_IDLE : ST_EMIT;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs and memory requests
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		res_valid      = (state_q == ST_EMIT);
		key_req.we     = do_place && (fill_q < LW'(GRID_CELLS));
		key_req.waddr  = fill_q;
		key_req.wdata  = put_letter;
		key_req.raddr  = (state_q == ST_KA) ? ta : tb;
		cell_req.we    = key_req.we;
		cell_req.waddr = put_letter;
		cell_req.wdata = fill_q;
		cell_req.raddr = (state_q == ST_CA) ? a_q : b_q;
	end

	assign res = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			seen_q  <= '0;
			fill_q  <= '0;
			ready_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q <= '0;
			end else if (state_q == ST_FILL) begin
				idx_q <= idx_q + 5'd1;
			end
			if (do_place) begin
				seen_q <= seen_q | (NUM_LETTERS'(1) << put_letter);
				if (fill_q < LW'(GRID_CELLS)) begin
					fill_q <= fill_q + 5'd1;
				end
			end
			if (state_q == ST_FILL && idx_q == LAST_CELL) begin
				ready_q <= 1'b1;
			end
		end
	end

	// request payload and result
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q         <= in_cmd;
			a_q           <= (in_cmd == CMD_DECRYPT) ? norm_cipher(in_a) : fold_j(in_a);
			b_q           <= norm_cipher(in_b);
			res_q.plain_a <= '0;
			res_q.plain_b <= '0;
			res_q.status  <= (in_cmd == CMD_DECRYPT && !ready_q) ? STAT_NOT_READY : STAT_OK;
		end
		if (state_q == ST_KEY && put_seen) begin
			res_q.status <= STAT_REPEAT;
		end
		if (state_q == ST_CB) begin
			ca_q <= cell_rdata;
		end
		if (state_q == ST_KA) begin
			cb_q <= cell_rdata;
		end
		if (state_q == ST_KB && cmd_q == CMD_DECRYPT) begin
			res_q.plain_a <= key_rdata;
		end
		if (state_q == ST_PB) begin
			res_q.plain_b <= key_rdata;
		end
	end

endmodule

// ----- hdl/playfair_decrypt_unit.sv -----
// Channel  Dir  Signals                              Contents
// s_*      in   s_tvalid s_tready s_tdata s_tuser    request: command, letter_a, letter_b
// m_*      out  m_tvalid m_tready m_tdata m_tuser    result: plain_a, plain_b, status
//
// A keyword letter passes ST_KEY, a decrypt pair ST_CA to ST_PB, a finish ST_FILL (one
// key square cell a cycle); a finish on a ready square or a decrypt before finish
// goes to ST_EMIT. Decrypt time is set by the single read port of each lookup memory.
// Reset clears the used-letter mask, the fill count and the ready flag; both
// memories start undefined and are only read once the square is complete.
// A result waits in the output register; s_tready stays low while a request runs
// or its result cannot yet be loaded.
module playfair_decrypt_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [4:0] letter_a, [9:5] letter_b, [15:10] zero
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [4:0] plain_a, [9:5] plain_b, [15:10] zero
	output logic [1:0]  m_tuser    // [1:0] status
);
	import pfd_pkg::*;

	ram_req_t      key_req, cell_req;
	logic [LW-1:0] key_rdata, cell_rdata;
	logic          res_valid, res_ready;
	result_t       res;
	result_t       out_q;
	logic          out_valid_q;

	pfd_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_cmd     (s_tuser),
		.in_a       (s_tdata[4:0]),
		.in_b       (s_tdata[9:5]),
		.key_req    (key_req),
		.key_rdata  (key_rdata),
		.cell_req   (cell_req),
		.cell_rdata (cell_rdata),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// letter in each cell, row-major
	pfd_ram #(.WIDTH(LW), .DEPTH(GRID_CELLS)) u_key_ram (
		.clk   (clk),
		.we    (key_req.we),
		.waddr (key_req.waddr),
		.wdata (key_req.wdata),
		.raddr (key_req.raddr),
		.rdata (key_rdata)
	);

	// cell of each letter
	pfd_ram #(.WIDTH(LW), .DEPTH(NUM_LETTERS)) u_cell_ram (
		.clk   (clk),
		.we    (cell_req.we),
		.waddr (cell_req.waddr),
		.wdata (cell_req.wdata),
		.raddr (cell_req.raddr),
		.rdata (cell_rdata)
	);

	// load the output register when it is empty or draining
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.plain_b, out_q.plain_a};
	assign m_tuser  = out_q.status;

	// s_tready is low in the cycle after an accept, while the request runs
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after accept");

	// a refused decrypt carries no letters
	a_not_ready_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STAT_NOT_READY) |-> (m_tdata == 16'd0))
		else $error("letters on a refused decrypt");

	// the square never holds J
	a_no_j_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[4:0] != LETTER_J && m_tdata[9:5] != LETTER_J))
		else $error("J in decrypted output");

endmodule
